@@ design/assert_macros.svh @@
// Concurrent assertion helpers, included by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge, masked while reset is asserted.
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_RST(name, clk, rstn, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ design/dcfd_pkg.sv @@
`default_nettype none

package dcfd_pkg;

  localparam int unsigned FrameLen = 60;
  localparam int unsigned PosW     = 6;

  localparam int unsigned PulseW = 10;
  localparam int unsigned PauseW = 12;
  localparam int unsigned MinW   = 7;
  localparam int unsigned HourW  = 6;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgZeroThr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOneThr  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGapThr  = 2'd2;

  localparam logic [PulseW-1:0] ZeroThrRst = 10'd150;
  localparam logic [PulseW-1:0] OneThrRst  = 10'd250;
  localparam logic [PauseW-1:0] GapThrRst  = 12'd1200;

  localparam logic [PosW-1:0] PosLast = 6'd59;

  // Frame layout
  localparam int unsigned StartBit  = 20;
  localparam int unsigned MinLo     = 21;
  localparam int unsigned MinOnesHi = 24;
  localparam int unsigned MinTensLo = 25;
  localparam int unsigned MinHi     = 27;
  localparam int unsigned MinPar    = 28;
  localparam int unsigned HourLo    = 29;
  localparam int unsigned HourOnesHi = 32;
  localparam int unsigned HourTensLo = 33;
  localparam int unsigned HourHi    = 34;
  localparam int unsigned HourPar   = 35;
  localparam int unsigned DateLo    = 36;
  localparam int unsigned DateHi    = 57;
  localparam int unsigned DatePar   = 58;

endpackage

`default_nettype wire

@@ design/dcf77_time_frame_decoder.sv @@
// Channel   Dir  Beat content (tdata from bit 0 up)
// s_axis    in   pulse_ms[9:0], pause_ms[21:10], zero pad to 24 bits
// m_axis    out  position[5:0], seen_frame_end[6], minute_value[13:7],
//                hour_value[19:14], minute_updated[20], hour_updated[21];
//                tlast = frame_end
// cfg       in   cfg_we_i / cfg_idx_i / cfg_wdata_i, one write per cycle
//
// One beat per cycle sustained while m_axis takes every result. An accepted beat lands
// in the input register, decodes into the result register when that register is free
// or being drained, and is valid on m_axis from then on.
// The decode is a single pass: bit write, 60-bit rotate, parity checks.
// Reset clears the frame, the position and the held time, and restores the
// threshold defaults.
// A stall on m_axis backs up into s_axis through the two registers.
`default_nettype none

`include "assert_macros.svh"

module dcf77_time_frame_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pulse_ms[9:0], pause_ms[21:10], pad [23:22]
  input  wire logic [dcfd_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // position[5:0], seen_frame_end[6], minute_value[13:7], hour_value[19:14],
  // minute_updated[20], hour_updated[21], pad [23:22]
  output logic [dcfd_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we_i,
  input  wire logic [dcfd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [dcfd_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  import dcfd_pkg::*;

  // Configuration
  logic [PulseW-1:0] zero_thr_q, one_thr_q;
  logic [PauseW-1:0] gap_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_thr_q <= ZeroThrRst;
      one_thr_q  <= OneThrRst;
      gap_thr_q  <= GapThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgZeroThr: zero_thr_q <= cfg_wdata_i[PulseW-1:0];
        CfgOneThr:  one_thr_q  <= cfg_wdata_i[PulseW-1:0];
        CfgGapThr:  gap_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic              in_valid_q;
  logic [PulseW-1:0] pulse_q;
  logic [PauseW-1:0] pause_q;
  logic              fire;

  assign fire          = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pulse_q <= s_axis_tdata[PulseW-1:0];
      pause_q <= s_axis_tdata[PulseW+PauseW-1:PulseW];
    end
  end

  // Decoder state
  logic [FrameLen-1:0] frame_q, frame_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                seen_q;
  logic [MinW-1:0]     min_q, min_d;
  logic [HourW-1:0]    hour_q, hour_d;

  logic [FrameLen-1:0]   frame_w, frame_rot;
  logic [2*FrameLen-1:0] frame_dbl;
  logic [PosW-1:0]       pos_inc, pos_rot, pos_out;
  logic                  mark, start_ok, date_ok, min_ok, hour_ok;
  logic                  min_upd, hour_upd;
  logic [MinW-1:0]       min_val;
  logic [HourW-1:0]      hour_val;
  logic [2:0]            min_tens;
  logic [1:0]            hour_tens;

  always_comb begin
    frame_w = frame_q;
    if (pulse_q < zero_thr_q) begin
      frame_w[pos_q] = 1'b0;
    end else if (pulse_q < one_thr_q) begin
      frame_w[pos_q] = 1'b1;
    end
    pos_inc = (pos_q == PosLast) ? '0 : pos_q + 1'b1;
    pos_rot = (pos_inc == PosLast) ? '0 : pos_inc + 1'b1;
    mark    = pause_q > gap_thr_q;

    // Rotate right within the 60-bit frame; zero amount leaves it unchanged
    frame_dbl = {frame_w, frame_w} >> pos_rot;
    frame_rot = frame_dbl[FrameLen-1:0];

    start_ok = frame_rot[StartBit];
    date_ok  = frame_rot[DatePar] == ^frame_rot[DateHi:DateLo];
    min_ok   = frame_rot[MinPar] == ^frame_rot[MinHi:MinLo];
    hour_ok  = frame_rot[HourPar] == ^frame_rot[HourHi:HourLo];
    min_upd  = mark && start_ok && date_ok && min_ok;
    hour_upd = mark && start_ok && date_ok && hour_ok;

    // tens * 10 as tens * 8 + tens * 2
    min_tens  = frame_rot[MinHi:MinTensLo];
    hour_tens = frame_rot[HourHi:HourTensLo];
    min_val   = {1'b0, min_tens, 3'b000} + {3'b000, min_tens, 1'b0}
              + {3'b000, frame_rot[MinOnesHi:MinLo]};
    hour_val  = {1'b0, hour_tens, 3'b000} + {3'b000, hour_tens, 1'b0}
              + {2'b00, frame_rot[HourOnesHi:HourLo]};

    frame_d = mark ? frame_rot : frame_w;
    pos_d   = mark ? '0 : pos_inc;
    pos_out = mark ? PosLast : pos_q;
    min_d   = min_upd ? min_val : min_q;
    hour_d  = hour_upd ? hour_val : hour_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      pos_q   <= '0;
      seen_q  <= 1'b0;
      min_q   <= '0;
      hour_q  <= '0;
    end else if (fire) begin
      frame_q <= frame_d;
      pos_q   <= pos_d;
      seen_q  <= seen_q || mark;
      min_q   <= min_d;
      hour_q  <= hour_d;
    end
  end

  // Result register
  logic            out_valid_q;
  logic [PosW-1:0] out_pos_q;
  logic            out_last_q, out_seen_q, out_min_upd_q, out_hour_upd_q;
  logic [MinW-1:0] out_min_q;
  logic [HourW-1:0] out_hour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pos_q      <= pos_out;
      out_last_q     <= mark;
      out_seen_q     <= seen_q || mark;
      out_min_q      <= min_d;
      out_hour_q     <= hour_d;
      out_min_upd_q  <= min_upd;
      out_hour_upd_q <= hour_upd;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_hour_upd_q, out_min_upd_q, out_hour_q, out_min_q,
                          out_seen_q, out_pos_q};

  `ASSERT_RST(a_pos_range, clk_i, rst_ni, pos_q <= PosLast)
  `ASSERT_RST(a_mark_pos, clk_i, rst_ni, out_valid_q && out_last_q |-> out_pos_q == PosLast)
  `ASSERT_RST(a_min_upd_mark, clk_i, rst_ni,
              out_valid_q && (out_min_upd_q || out_hour_upd_q) |-> out_last_q)
  `ASSERT_RST(a_mark_restart, clk_i, rst_ni, fire && mark |=> pos_q == '0)
  `ASSERT_RST(a_seen_sticky, clk_i, rst_ni, seen_q |=> seen_q)

endmodule

`default_nettype wire

@@ bench/dcf77_decode_checker.sv @@
`default_nettype none

module dcf77_decode_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  // pulse_ms[9:0], pause_ms[21:10], pad [23:22]
  input  wire logic [dcfd_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // position[5:0], seen_frame_end[6], minute_value[13:7], hour_value[19:14],
  // minute_updated[20], hour_updated[21], pad [23:22]
  input  wire logic [dcfd_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire logic                          m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dcfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);

  import dcfd_pkg::*;

  typedef struct {
    logic [PosW-1:0]  position;
    logic             frame_end;
    logic             seen_frame_end;
    logic [MinW-1:0]  minute_value;
    logic [HourW-1:0] hour_value;
    logic             minute_updated;
    logic             hour_updated;
  } decode_t;

  logic [PulseW-1:0]   zero_thr;
  logic [PulseW-1:0]   one_thr;
  logic [PauseW-1:0]   gap_thr;
  logic [FrameLen-1:0] frame;
  int unsigned         bit_pos;
  logic                seen_mark;
  logic [MinW-1:0]     minutes;
  logic [HourW-1:0]    hours;
  decode_t             decode_q[$];
  int unsigned         errs;

  function automatic decode_t decode_beat(input logic [PulseW-1:0] pulse,
                                          input logic [PauseW-1:0] pause);
    decode_t     r;
    int unsigned p;
    r = '{default: '0};
    p = bit_pos % FrameLen;
    if (pulse < zero_thr) begin
      frame[p] = 1'b0;
    end else if (pulse < one_thr) begin
      frame[p] = 1'b1;
    end
    p = (p + 1) % FrameLen;
    if (pause > gap_thr) begin
      r.frame_end = 1'b1;
      p = (p + 1) % FrameLen;
      if (p != 0) begin
        frame = (frame >> p) | (frame << (FrameLen - p));
      end
      p = 0;
      seen_mark = 1'b1;
      // Start bit and date parity gate both fields; each has its own parity.
      if (frame[StartBit] && frame[DatePar] == ^frame[DateHi:DateLo]) begin
        if (frame[MinPar] == ^frame[MinHi:MinLo]) begin
          minutes = MinW'(10 * frame[MinHi:MinTensLo] + frame[MinOnesHi:MinLo]);
          r.minute_updated = 1'b1;
        end
        if (frame[HourPar] == ^frame[HourHi:HourLo]) begin
          hours = HourW'(10 * frame[HourHi:HourTensLo] + frame[HourOnesHi:HourLo]);
          r.hour_updated = 1'b1;
        end
      end
    end
    bit_pos = p;
    r.position       = PosW'((p + 59) % FrameLen);
    r.seen_frame_end = seen_mark;
    r.minute_value   = minutes;
    r.hour_value     = hours;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decode_t want;
    if (!rst_ni) begin
      zero_thr  = ZeroThrRst;
      one_thr   = OneThrRst;
      gap_thr   = GapThrRst;
      frame     = '0;
      bit_pos   = 0;
      seen_mark = 1'b0;
      minutes   = '0;
      hours     = '0;
      decode_q.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgZeroThr: zero_thr = cfg_wdata_i[PulseW-1:0];
          CfgOneThr:  one_thr  = cfg_wdata_i[PulseW-1:0];
          CfgGapThr:  gap_thr  = cfg_wdata_i[PauseW-1:0];
          default: ;
        endcase
      end
      // Compare before queueing so a fresh beat can never cover a stray result.
      if (m_axis_tvalid && m_axis_tready) begin
        if (decode_q.size() == 0) begin
          errs++;
          $error("result beat arrived with nothing expected");
        end else begin
          want = decode_q.pop_front();
          check_field("position", want.position, m_axis_tdata[5:0]);
          check_field("frame_end", want.frame_end, m_axis_tlast);
          check_field("seen_frame_end", want.seen_frame_end, m_axis_tdata[6]);
          check_field("minute_value", want.minute_value, m_axis_tdata[13:7]);
          check_field("hour_value", want.hour_value, m_axis_tdata[19:14]);
          check_field("minute_updated", want.minute_updated, m_axis_tdata[20]);
          check_field("hour_updated", want.hour_updated, m_axis_tdata[21]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_q.push_back(decode_beat(s_axis_tdata[PulseW-1:0],
                                       s_axis_tdata[PulseW +: PauseW]));
      end
      fail_count_o <= errs;
      pending_o    <= decode_q.size();
    end
  end

endmodule

`default_nettype wire

@@ bench/dcf77_time_frame_decoder_tb.sv @@
`default_nettype none

module dcf77_time_frame_decoder_tb;
  import dcfd_pkg::*;

  localparam int unsigned StuckLimit = 1000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stuck = 0;

  // Stimulus-side copy of the thresholds and bit position, used only to shape
  // pulses and pauses into frames.
  int unsigned zero_ms;
  int unsigned one_ms;
  int unsigned gap_ms;
  int unsigned frame_pos;
  bit          tx_calm;

  dcf77_time_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  dcf77_decode_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= StuckLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin : receiver
    int unsigned got;
    int unsigned stall;
    bit          rx_calm;
    got = 0;
    rx_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (got % 64 == 0) rx_calm = ($urandom_range(3, 0) == 0);
      stall = rx_calm ? 0 : $urandom_range(4, 0);
      if (got == 300) stall = 200;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got++;
    end
  end

  task automatic send_beat(input logic [PulseW-1:0] pulse, input logic [PauseW-1:0] pause);
    int unsigned idle;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pause, pulse};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_pos = (frame_pos + 1) % FrameLen;
    if (pause > gap_ms) frame_pos = 0;
    idle = tx_calm ? 0 : $urandom_range(4, 0);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Wait until every beat sent so far has come back out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgZeroThr: zero_ms = val[PulseW-1:0];
      CfgOneThr:  one_ms  = val[PulseW-1:0];
      CfgGapThr:  gap_ms  = val[PauseW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [CfgDataW-1:0] zero_val,
                                input logic [CfgDataW-1:0] one_val,
                                input logic [CfgDataW-1:0] gap_val);
    drain();
    cfg_write(CfgZeroThr, zero_val);
    cfg_write(CfgOneThr, one_val);
    cfg_write(CfgGapThr, gap_val);
    cfg_write(CfgUnused, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PulseW-1:0] pulse_for(input bit value);
    int unsigned top_thr;
    top_thr = (zero_ms > one_ms) ? zero_ms : one_ms;
    if ($urandom_range(19, 0) != 0) begin
      if (!value && zero_ms > 0) return PulseW'($urandom_range(zero_ms - 1, 0));
      if (value && one_ms > zero_ms) return PulseW'($urandom_range(one_ms - 1, zero_ms));
    end
    // Long pulse: leave the bit as it is.
    return PulseW'($urandom_range(1023, top_thr));
  endfunction

  function automatic logic [PauseW-1:0] plain_pause();
    return PauseW'($urandom_range(gap_ms, 0));
  endfunction

  function automatic logic [PauseW-1:0] mark_pause();
    return PauseW'($urandom_range(4095, gap_ms + 1));
  endfunction

  // One minute of the time code with random bit content; some frames are
  // damaged (start bit, a parity, or cut short / overlong).
  task automatic send_frame();
    logic [FrameLen-1:0] bits;
    int unsigned         flaw;
    int unsigned         last;
    tx_calm = ($urandom_range(3, 0) == 0);
    if (frame_pos != 0) send_beat(pulse_for($urandom_range(1, 0)), mark_pause());
    bits = FrameLen'({$urandom, $urandom});
    bits[StartBit] = 1'b1;
    bits[MinPar]   = ^bits[MinHi:MinLo];
    bits[HourPar]  = ^bits[HourHi:HourLo];
    bits[DatePar]  = ^bits[DateHi:DateLo];
    flaw = $urandom_range(14, 0);
    last = 58;
    case (flaw)
      0: bits[StartBit] = 1'b0;
      1: bits[MinPar]   = ~bits[MinPar];
      2: bits[HourPar]  = ~bits[HourPar];
      3: bits[DatePar]  = ~bits[DatePar];
      4: last = $urandom_range(57, 1);
      5: last = 59;
      default: ;
    endcase
    for (int unsigned i = 0; i <= last; i++) begin
      send_beat(pulse_for(bits[i % FrameLen]), (i == last) ? mark_pause() : plain_pause());
    end
  endtask

  task automatic send_noise(input int unsigned count);
    logic [PauseW-1:0] pause;
    tx_calm = ($urandom_range(3, 0) == 0);
    repeat (count) begin
      pause = ($urandom_range(3, 0) == 0) ? PauseW'($urandom_range(4095, 0)) : plain_pause();
      send_beat(PulseW'($urandom_range(1023, 0)), pause);
    end
  endtask

  initial begin : stimulus
    int unsigned z;
    int unsigned o;
    int unsigned g;
    zero_ms   = ZeroThrRst;
    one_ms    = OneThrRst;
    gap_ms    = GapThrRst;
    frame_pos = 0;
    tx_calm   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes, threshold edges, and early minute marks that rotate.
    send_beat(10'd0, 12'd0);
    send_beat(10'd1023, 12'd4095);
    send_beat(10'd149, 12'd1200);
    send_beat(10'd150, 12'd1201);
    send_beat(10'd249, 12'd0);
    send_beat(10'd250, 12'd1);
    send_beat(10'h2AA, 12'hAAA);
    send_beat(10'h155, 12'h555);
    repeat (4) send_beat(10'd200, 12'd100);
    send_beat(10'd100, 12'd2000);
    repeat (3) send_beat(10'd0, 12'd0);
    send_beat(10'd1023, 12'd1199);
    send_beat(10'd200, 12'd1201);

    repeat (8) send_frame();
    send_noise(60);

    // Zero threshold 0, one threshold max, gap 0: every nonzero pause is a mark.
    set_thresholds(12'hC00, 12'hFFF, 12'h000);
    send_noise(40);
    repeat (4) send_frame();

    // Thresholds out of order and no minute mark possible.
    set_thresholds(12'h3FF, 12'h000, 12'hFFF);
    send_noise(150);

    set_thresholds(12'd300, 12'd100, 12'd2000);
    repeat (3) send_frame();
    send_noise(40);

    z = $urandom_range(400, 20);
    o = $urandom_range(1023, z + 1);
    g = $urandom_range(4000, 100);
    set_thresholds({2'($urandom_range(3, 0)), z[9:0]},
                   {2'($urandom_range(3, 0)), o[9:0]}, g[11:0]);
    repeat (8) send_frame();
    send_noise(60);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
